/* rtl/dlt_pkg.sv */
package dlt_pkg;

    // Fixed geometry of the tables, set by the field widths.
    localparam int STATE_W      = 6;
    localparam int SYM_W        = 8;
    localparam int TOKEN_W      = 8;
    localparam int POS_W        = 16;
    localparam int STATES       = 64;
    localparam int TRANS_AW     = STATE_W + SYM_W;
    localparam int TRANS_DEPTH  = 2 ** TRANS_AW;
    localparam int ACC_W        = TOKEN_W + 1;
    localparam int LOOKBACK_DEF = 16;

    // Configuration port geometry and register index.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DEAD_STATE = 1'b0;
    localparam logic [STATE_W-1:0] DEAD_STATE_RST = 6'd63;

    localparam logic [7:0] NEWLINE = 8'h0A;
    localparam logic [POS_W-1:0] LINE_RST   = 16'd1;
    localparam logic [POS_W-1:0] COLUMN_RST = 16'd0;

    typedef enum logic [1:0] {
        KIND_WR_TRANS = 2'd0,
        KIND_WR_ACC   = 2'd1,
        KIND_DATA     = 2'd2,
        KIND_EOI      = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [STATE_W-1:0]   entry_state;
        logic [SYM_W-1:0]     entry_symbol;
        logic [STATE_W-1:0]   entry_next;
        logic                 accept_valid;
        logic [TOKEN_W-1:0]   accept_token;
        logic [7:0]           data_byte;
    } in_item_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] token_id;
        logic               token_error;
        logic [POS_W-1:0]   token_length;
        logic [POS_W-1:0]   start_line;
        logic [POS_W-1:0]   start_column;
        logic               last_of_run;
    } token_t;

    // Scan step performed by the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_FIRST_DEAD,
        OP_FIRST_LIVE,
        OP_EXTEND,
        OP_RESCAN,
        OP_EOI_RESET
    } step_op_t;

    typedef struct packed {
        logic     take;
        logic     rd_trans;
        logic     rd_acc;
        logic     flush;
        step_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic q_empty;
        logic lex_zero;
        logic dead;
        logic overflow;
        logic can_emit;
        logic out_free;
        logic pend_valid;
    } dp_status_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == {POS_W{1'b1}}) ? v : v + 16'd1;
    endfunction

endpackage

/* rtl/dlt_ctrl.sv */
module dlt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  dlt_pkg::kind_t       s_kind,
    output logic                 s_ready,
    input  dlt_pkg::dp_status_t  status,
    output dlt_pkg::dp_cmd_t     cmd
);
    import dlt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TRANS,
        S_ACC,
        S_FINISH,
        S_LAST
    } state_t;

    state_t state_reg, state_next;
    logic   eoi_reg, eoi_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and the step command for the datapath.
    always_comb begin
        state_next = state_reg;
        eoi_next   = eoi_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    unique case (s_kind)
                        KIND_DATA: begin
                            state_next = S_READ;
                            eoi_next   = 1'b0;
                        end
                        KIND_EOI: begin
                            state_next = S_FINISH;
                            eoi_next   = 1'b1;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (status.q_empty) begin
                    state_next = eoi_reg ? S_FINISH : S_LAST;
                end else begin
                    cmd.rd_trans = 1'b1;
                    state_next   = S_TRANS;
                end
            end
            S_TRANS: begin
                if (!status.dead) begin
                    cmd.rd_acc = 1'b1;
                    state_next = S_ACC;
                end else if (status.can_emit) begin
                    cmd.op     = status.lex_zero ? OP_FIRST_DEAD : OP_RESCAN;
                    state_next = S_READ;
                end
            end
            S_ACC: begin
                if (status.lex_zero) begin
                    cmd.op     = OP_FIRST_LIVE;
                    state_next = S_READ;
                end else if (!status.overflow || status.can_emit) begin
                    cmd.op     = OP_EXTEND;
                    state_next = S_READ;
                end
            end
            S_FINISH: begin
                // End of input: flush the open lexeme and rescan what is held.
                if (!status.lex_zero) begin
                    if (status.can_emit) begin
                        cmd.op     = OP_RESCAN;
                        state_next = S_READ;
                    end
                end else begin
                    cmd.op     = OP_EOI_RESET;
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                // The held token is the last of this request.
                if (!status.pend_valid) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            eoi_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            eoi_reg   <= eoi_next;
        end
    end

endmodule

/* rtl/dlt_datapath.sv */
module dlt_datapath #(
    parameter int LOOKBACK = dlt_pkg::LOOKBACK_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dlt_pkg::in_item_t             s_data,
    input  logic [dlt_pkg::STATE_W-1:0]   dead_state_id,
    input  dlt_pkg::dp_cmd_t              cmd,
    output dlt_pkg::dp_status_t           status,
    input  logic                          m_ready,
    output logic                          m_valid,
    output dlt_pkg::token_t               m_data
);
    import dlt_pkg::*;

    localparam int CW    = $clog2(LOOKBACK + 1);
    localparam int DEPTH = 2 ** CW;

    // Tables and the lookback ring.
    logic [STATE_W-1:0] trans_mem [TRANS_DEPTH];
    logic [ACC_W-1:0]   acc_mem   [STATES];
    logic [7:0]         ring_reg  [DEPTH];
    logic [STATE_W-1:0] trans_q_reg;
    logic [ACC_W-1:0]   acc_q_reg;

    // Ring pointers: held bytes start at base, the queue follows them.
    logic [CW-1:0]      base_reg, held_reg, queue_reg;
    logic [STATE_W-1:0] scan_reg;
    logic               best_valid_reg;
    logic [TOKEN_W-1:0] best_id_reg;
    logic [POS_W-1:0]   best_len_reg, lex_reg;
    logic [POS_W-1:0]   cur_line_reg, cur_col_reg;
    logic [POS_W-1:0]   me_line_reg, me_col_reg;
    logic [POS_W-1:0]   ts_line_reg, ts_col_reg;

    token_t pend_reg, out_reg;
    logic   pend_valid_reg, out_valid_reg;

    logic [CW-1:0]       head_idx, tail_idx;
    logic [7:0]          cur_byte;
    logic                lex_zero, is_nl, acc_hit, held_full, overflow;
    logic                dead, out_free, can_emit, emit_en, out_load;
    logic [TRANS_AW-1:0] trans_addr;
    logic [POS_W-1:0]    nc_line, nc_col, new_lex;
    token_t              emit_tok;
    token_t              load_tok;

    assign head_idx   = base_reg + held_reg;
    assign tail_idx   = head_idx + queue_reg;
    assign cur_byte   = ring_reg[head_idx];
    assign lex_zero   = (lex_reg == '0);
    assign trans_addr = {(lex_zero ? {STATE_W{1'b0}} : scan_reg), cur_byte};
    assign is_nl      = (cur_byte == NEWLINE);
    assign nc_line    = is_nl ? sat_inc(cur_line_reg) : cur_line_reg;
    assign nc_col     = is_nl ? COLUMN_RST : sat_inc(cur_col_reg);
    assign new_lex    = sat_inc(lex_reg);
    assign dead       = (trans_q_reg == dead_state_id);
    assign acc_hit    = acc_q_reg[ACC_W-1];
    assign held_full  = ((CW+1)'(held_reg) + (CW+1)'(1)) >= (CW+1)'(LOOKBACK);
    assign overflow   = !lex_zero && !acc_hit && held_full;
    assign out_free   = !out_valid_reg || m_ready;
    assign can_emit   = !pend_valid_reg || out_free;

    assign status.q_empty    = (queue_reg == '0);
    assign status.lex_zero   = lex_zero;
    assign status.dead       = dead;
    assign status.overflow   = overflow;
    assign status.can_emit   = can_emit;
    assign status.out_free   = out_free;
    assign status.pend_valid = pend_valid_reg;

    // Token built by the current step, if it produces one.
    always_comb begin
        emit_en  = 1'b0;
        emit_tok = '0;
        emit_tok.start_line   = ts_line_reg;
        emit_tok.start_column = ts_col_reg;
        unique case (cmd.op)
            OP_FIRST_DEAD: begin
                emit_en               = 1'b1;
                emit_tok.token_error  = 1'b1;
                emit_tok.token_length = 16'd1;
                emit_tok.start_line   = nc_line;
                emit_tok.start_column = nc_col;
            end
            OP_RESCAN: begin
                emit_en = 1'b1;
                if (best_valid_reg) begin
                    emit_tok.token_id     = best_id_reg;
                    emit_tok.token_length = best_len_reg;
                end else begin
                    emit_tok.token_error  = 1'b1;
                    emit_tok.token_length = 16'd1;
                end
            end
            OP_EXTEND: begin
                emit_en               = overflow;
                emit_tok.token_id     = best_valid_reg ? best_id_reg : '0;
                emit_tok.token_error  = 1'b1;
                emit_tok.token_length = new_lex;
            end
            default: emit_en = 1'b0;
        endcase
    end

    assign out_load = pend_valid_reg && (emit_en || cmd.flush);

    // The held token leaves with the last-of-run flag set only on the final flush.
    always_comb begin
        load_tok             = pend_reg;
        load_tok.last_of_run = cmd.flush;
    end

    // Table writes and registered table reads.
    always_ff @(posedge aclk) begin
        if (cmd.take && s_data.kind == KIND_WR_TRANS) begin
            trans_mem[{s_data.entry_state, s_data.entry_symbol}] <= s_data.entry_next;
        end
        if (cmd.rd_trans) begin
            trans_q_reg <= trans_mem[trans_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && s_data.kind == KIND_WR_ACC) begin
            acc_mem[s_data.entry_state] <= {s_data.accept_valid, s_data.accept_token};
        end
        if (cmd.rd_acc) begin
            acc_q_reg <= acc_mem[trans_q_reg];
        end
    end

    // Incoming data bytes join the tail of the ring.
    always_ff @(posedge aclk) begin
        if (cmd.take && s_data.kind == KIND_DATA) begin
            ring_reg[tail_idx] <= s_data.data_byte;
        end
    end

    // Scan state, positions and ring pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            held_reg       <= '0;
            queue_reg      <= '0;
            scan_reg       <= '0;
            best_valid_reg <= 1'b0;
            best_id_reg    <= '0;
            best_len_reg   <= '0;
            lex_reg        <= '0;
            cur_line_reg   <= LINE_RST;
            cur_col_reg    <= COLUMN_RST;
            me_line_reg    <= LINE_RST;
            me_col_reg     <= COLUMN_RST;
            ts_line_reg    <= LINE_RST;
            ts_col_reg     <= COLUMN_RST;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.take && s_data.kind == KIND_DATA) begin
                queue_reg <= CW'(1);
            end
            unique case (cmd.op)
                OP_FIRST_DEAD: begin
                    cur_line_reg <= nc_line;
                    cur_col_reg  <= nc_col;
                    me_line_reg  <= nc_line;
                    me_col_reg   <= nc_col;
                    ts_line_reg  <= nc_line;
                    ts_col_reg   <= nc_col;
                    base_reg     <= base_reg + CW'(1);
                    queue_reg    <= queue_reg - CW'(1);
                end
                OP_FIRST_LIVE: begin
                    cur_line_reg <= nc_line;
                    cur_col_reg  <= nc_col;
                    me_line_reg  <= nc_line;
                    me_col_reg   <= nc_col;
                    ts_line_reg  <= nc_line;
                    ts_col_reg   <= nc_col;
                    lex_reg      <= 16'd1;
                    scan_reg     <= trans_q_reg;
                    if (acc_hit) begin
                        best_valid_reg <= 1'b1;
                        best_id_reg    <= acc_q_reg[TOKEN_W-1:0];
                        best_len_reg   <= 16'd1;
                    end
                    base_reg  <= base_reg + CW'(1);
                    queue_reg <= queue_reg - CW'(1);
                end
                OP_EXTEND: begin
                    cur_line_reg <= nc_line;
                    cur_col_reg  <= nc_col;
                    queue_reg    <= queue_reg - CW'(1);
                    if (acc_hit) begin
                        lex_reg        <= new_lex;
                        scan_reg       <= trans_q_reg;
                        best_valid_reg <= 1'b1;
                        best_id_reg    <= acc_q_reg[TOKEN_W-1:0];
                        best_len_reg   <= new_lex;
                        me_line_reg    <= nc_line;
                        me_col_reg     <= nc_col;
                        base_reg       <= base_reg + held_reg + CW'(1);
                        held_reg       <= '0;
                    end else if (held_full) begin
                        // Lookback overflow: the whole lexeme went out as an error.
                        lex_reg        <= '0;
                        scan_reg       <= '0;
                        best_valid_reg <= 1'b0;
                        best_id_reg    <= '0;
                        best_len_reg   <= '0;
                        base_reg       <= base_reg + held_reg + CW'(1);
                        held_reg       <= '0;
                    end else begin
                        lex_reg  <= new_lex;
                        scan_reg <= trans_q_reg;
                        held_reg <= held_reg + CW'(1);
                    end
                end
                OP_RESCAN: begin
                    // Held bytes move back in front of the queue.
                    cur_line_reg   <= me_line_reg;
                    cur_col_reg    <= me_col_reg;
                    lex_reg        <= '0;
                    scan_reg       <= '0;
                    best_valid_reg <= 1'b0;
                    best_id_reg    <= '0;
                    best_len_reg   <= '0;
                    queue_reg      <= queue_reg + held_reg;
                    held_reg       <= '0;
                end
                OP_EOI_RESET: begin
                    cur_line_reg <= LINE_RST;
                    cur_col_reg  <= COLUMN_RST;
                    me_line_reg  <= LINE_RST;
                    me_col_reg   <= COLUMN_RST;
                    ts_line_reg  <= LINE_RST;
                    ts_col_reg   <= COLUMN_RST;
                end
                default: ;
            endcase

            // A new token pushes the held one to the output register.
            if (emit_en) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Token payload registers.
    always_ff @(posedge aclk) begin
        if (emit_en) begin
            pend_reg <= emit_tok;
        end
        if (out_load) begin
            out_reg <= load_tok;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/dfa_longest_match_tokenizer_unit.sv */
// Table-driven longest-match tokenizer.
// Input channel (s_valid/s_ready/s_data) carries one request at a time: a
// transition-table write, an accept-table write, one data byte, or end of
// input. Result channel (m_valid/m_ready/m_data) carries tokens with id,
// error flag, length and start position; last_of_run marks the final token
// caused by a request. The APB port holds the dead state id (addresses 0 to 3).
// A table write is done as it is taken. Each scanned byte passes through the
// ring read and transition lookup, the registered transition table read, and
// the registered accept table read, which a dead transition skips. A byte
// request also passes through its acceptance, the empty-queue check and the
// release of the last token; an end of input with no open lexeme passes
// through acceptance, the position reset and the release. A dead transition
// adds a rescan of up to LOOKBACK-1 held bytes, scanned again in the same
// steps. A request is taken only while idle.
// The token caused by a byte is held one step until the next token or the end
// of the request is known. Reset clears the scan state, positions and output
// registers; the tables hold no reset value and must be written before use.
// When the receiver stalls, one token waits in the output register and one
// more is held inside; a step that makes another token waits for m_ready.
module dfa_longest_match_tokenizer_unit #(
    parameter int LOOKBACK = dlt_pkg::LOOKBACK_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dlt_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dlt_pkg::token_t               m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlt_pkg::PADDR_W-1:0]   paddr,
    input  logic [dlt_pkg::PDATA_W-1:0]   pwdata,
    output logic [dlt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import dlt_pkg::*;

    logic [STATE_W-1:0] dead_state_reg;
    logic               cfg_sel;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // Configuration register.
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1] == REG_DEAD_STATE);
    assign prdata  = cfg_sel ? PDATA_W'(dead_state_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_state_reg <= DEAD_STATE_RST;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            dead_state_reg <= pwdata[STATE_W-1:0];
        end
    end

    dlt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dlt_datapath #(
        .LOOKBACK (LOOKBACK)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .dead_state_id (dead_state_reg),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_data        (m_data)
    );

    // When idle, no bytes are queued and no token is left unreleased.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (status.q_empty && !status.pend_valid))
        else $error("idle with queued bytes or a held token");

    // Steps that always produce a token only run with room for it.
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIRST_DEAD || cmd.op == OP_RESCAN) |-> status.can_emit)
        else $error("token produced without room");

    // A flush leaves the final token, marked last of run, in the output register.
    a_flush_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> (m_valid && m_data.last_of_run))
        else $error("final token not presented");

endmodule
